// File: src/stirling_first_kind_mod_prime_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Stirling number block
// Immediate-implication and next-cycle-implication property shorthands.
// ---------------------------------------------------------------------------
`ifndef STIRLING_FIRST_KIND_MOD_PRIME_TOP_MACROS_SVH
`define STIRLING_FIRST_KIND_MOD_PRIME_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define SFK_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define SFK_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/sfk_pkg.sv
// ---------------------------------------------------------------------------
// sfk_pkg
// Shared widths, modulus and transaction types of the Stirling number block.
// ---------------------------------------------------------------------------
package sfk_pkg;

  localparam int unsigned MAX_N_DEFAULT = 1024;
  localparam int ITEMS_W    = 11;
  localparam int COUNT_W    = 30;
  // widest row address for any legal MAX_N (up to 65535)
  localparam int ADDR_W_MAX = 16;

  localparam logic [COUNT_W-1:0] MODULUS = 30'd1000000007;

  typedef struct packed {
    logic [ITEMS_W-1:0] items;
    logic [ITEMS_W-1:0] visible;
  } query_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
  } answer_t;

  // one row update: addr <= (mult * prod_src + addend) mod MODULUS
  typedef struct packed {
    logic                  valid;
    logic [ADDR_W_MAX-1:0] mult;
    logic [COUNT_W-1:0]    prod_src;
    logic [COUNT_W-1:0]    addend;
    logic [ADDR_W_MAX-1:0] addr;
  } mm_req_t;

  // row memory write port
  typedef struct packed {
    logic                  en;
    logic [ADDR_W_MAX-1:0] addr;
    logic [COUNT_W-1:0]    data;
  } row_wr_t;

endpackage

// File: src/sfk_stream_if.sv
// ---------------------------------------------------------------------------
// sfk_stream_if
// Valid/ready channel carrying one payload per transaction.
// ---------------------------------------------------------------------------
interface sfk_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// File: src/sfk_row_ram.sv
// ---------------------------------------------------------------------------
// sfk_row_ram
// One-row store: single write port, single registered read port.
// ---------------------------------------------------------------------------
module sfk_row_ram import sfk_pkg::*; #(
  parameter int AW    = 11,
  parameter int DEPTH = 1025
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [COUNT_W-1:0] rd_data,
  input  row_wr_t            wr
);

  logic [COUNT_W-1:0] mem [DEPTH];

  // write and read, read data registered
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/sfk_mulmod.sv
// ---------------------------------------------------------------------------
// sfk_mulmod
// Pipelined multiply-add with Barrett reduction modulo 1000000007.
// Six stages; result is a write to the row store.
// ---------------------------------------------------------------------------
module sfk_mulmod import sfk_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  mm_req_t req,
  output row_wr_t wr,
  output logic    busy
);

  // x = mult * prod_src + addend stays below 2^XW
  localparam int XW = ADDR_W_MAX + COUNT_W;
  // top bits of x used for the quotient estimate
  localparam int SW = XW - (COUNT_W - 1);
  localparam int QW = 2 * SW;
  // remainder before correction is below 3 * MODULUS
  localparam int RW = COUNT_W + 2;
  localparam logic [63:0]   RECIP_FULL = (64'd1 << XW) / 64'(MODULUS);
  localparam logic [SW-1:0] RECIP      = RECIP_FULL[SW-1:0];
  localparam logic [RW-1:0] ONE_P      = RW'(MODULUS);
  localparam logic [RW-1:0] TWO_P      = RW'(MODULUS) << 1;

  logic [4:0]            v;
  logic [ADDR_W_MAX-1:0] addr_s [5];

  logic [XW-1:0]      prod1;
  logic [COUNT_W-1:0] add1;
  logic [XW-1:0]      x2, x3, x4;
  logic [QW-1:0]      qe3;
  logic [XW-1:0]      qp4;
  logic [RW-1:0]      r5;
  logic [RW-1:0]      r5_m1, r5_m2;
  logic [COUNT_W-1:0] red;

  logic                  wr_en;
  logic [ADDR_W_MAX-1:0] wr_addr;
  logic [COUNT_W-1:0]    wr_data;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v     <= '0;
      wr_en <= 1'b0;
    end else begin
      v     <= {v[3:0], req.valid};
      wr_en <= v[4];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    addr_s[0] <= req.addr;
    addr_s[1] <= addr_s[0];
    addr_s[2] <= addr_s[1];
    addr_s[3] <= addr_s[2];
    addr_s[4] <= addr_s[3];
    wr_addr   <= addr_s[4];
    // product and addend
    prod1 <= XW'(req.mult) * XW'(req.prod_src);
    add1  <= req.addend;
    x2    <= prod1 + XW'(add1);
    // quotient estimate from the top bits
    x3    <= x2;
    qe3   <= QW'(x2[XW-1:XW-SW]) * QW'(RECIP);
    x4    <= x3;
    qp4   <= XW'(qe3[QW-1:SW]) * XW'(MODULUS);
    // estimate never exceeds the true quotient
    r5    <= RW'(x4 - qp4);
    wr_data <= red;
  end

  // final correction: at most two subtractions of the modulus
  always_comb begin
    r5_m1 = r5 - ONE_P;
    r5_m2 = r5 - TWO_P;
    priority if (r5 >= TWO_P) begin
      red = r5_m2[COUNT_W-1:0];
    end else if (r5 >= ONE_P) begin
      red = r5_m1[COUNT_W-1:0];
    end else begin
      red = r5[COUNT_W-1:0];
    end
  end

  assign wr   = '{en: wr_en, addr: wr_addr, data: wr_data};
  assign busy = (|v) || wr_en;

endmodule

// File: src/stirling_first_kind_mod_prime_top.sv
// ---------------------------------------------------------------------------
// stirling_first_kind_mod_prime_top
// Unsigned Stirling numbers of the first kind c(n,k) modulo 1000000007,
// built row by row in a one-row store: c(j,m) = c(j-1,m-1) + (j-1)*c(j-1,m).
//
//   channel  | side   | payload                 | handshake
//   ---------+--------+-------------------------+-----------
//   query    | sink   | items[10:0] visible[10:0]| valid/ready
//   answer   | source | count[29:0]             | valid/ready
//
// Trivial queries (items == visible, visible > items, visible == 0,
// items > MAX_N) skip the row sweep and go straight to the output register.
// Otherwise a query builds each row j=1..n in turn, at the cost of one
// row-store read per update, plus a drain of the six-stage multiply/reduce
// pipeline at the end of every row.
// One query in work at a time; a new query is taken while the previous
// answer waits in the output register. Reset is synchronous; no clearing
// pass (every row entry is written before it is read).
// ---------------------------------------------------------------------------
module stirling_first_kind_mod_prime_top import sfk_pkg::*; #(
  parameter int unsigned MAX_N = MAX_N_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  sfk_stream_if.sink    query,
  sfk_stream_if.source  answer
);

  localparam int AW    = $clog2(MAX_N + 1);
  localparam int DEPTH = MAX_N + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW,
    S_DRAIN,
    S_FETCH,
    S_LOAD,
    S_DONE
  } state_t;

  state_t state;

  logic [AW-1:0] n_r, k_r, j_r, top_r, ra_r;
  logic [AW-1:0] j_next, top_next;

  // read in flight (row phase)
  logic          rd_pend;
  logic          rd_prime;
  logic [AW-1:0] rd_addr_q;

  logic [COUNT_W-1:0] cur_r;
  logic [COUNT_W-1:0] res_r;
  logic [COUNT_W-1:0] out_count;
  logic               out_v;

  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [COUNT_W-1:0] rd_data;
  logic [COUNT_W-1:0] addend_val;

  logic               is_special;
  logic [COUNT_W-1:0] special_val;

  mm_req_t mm_req;
  row_wr_t row_wr;
  logic    mm_busy;

  // trivial queries resolved at the transaction
  always_comb begin
    is_special = (query.data.items == query.data.visible)
              || (query.data.visible > query.data.items)
              || (query.data.visible == '0)
              || (32'(query.data.items) > 32'(MAX_N));
    special_val = (query.data.items == query.data.visible) ? COUNT_W'(1) : '0;
  end

  // next row bounds
  always_comb begin
    j_next   = j_r + AW'(1);
    top_next = (j_next < k_r) ? j_next : k_r;
  end

  // memory read port shared by the row sweep and the final fetch
  assign rd_en   = (state == S_ROW) || (state == S_FETCH);
  assign rd_addr = (state == S_FETCH) ? k_r : ra_r;

  // entry 0 of the row is 1 before the first row and 0 after it
  assign addend_val = (rd_addr_q == '0) ? ((j_r == AW'(1)) ? COUNT_W'(1) : '0)
                                        : rd_data;

  assign mm_req = '{valid:    rd_pend && !rd_prime,
                    mult:     ADDR_W_MAX'(j_r - AW'(1)),
                    prod_src: cur_r,
                    addend:   addend_val,
                    addr:     ADDR_W_MAX'(rd_addr_q) + ADDR_W_MAX'(1)};

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
      out_v   <= 1'b0;
    end else begin
      rd_pend <= (state == S_ROW);
      if (state == S_ROW) begin
        rd_prime  <= (ra_r == top_r);
        rd_addr_q <= ra_r;
      end
      // returned data: old c(j-1,m) becomes the multiplicand of the next step
      if (rd_pend) begin
        if (rd_prime) begin
          cur_r <= (top_r == j_r) ? '0 : rd_data;
        end else begin
          cur_r <= addend_val;
        end
      end
      // in S_DONE the output register is reloaded instead
      if (answer.valid && answer.ready && (state != S_DONE)) begin
        out_v <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (query.valid) begin
            if (is_special) begin
              res_r <= special_val;
              state <= S_DONE;
            end else begin
              n_r   <= AW'(query.data.items);
              k_r   <= AW'(query.data.visible);
              j_r   <= AW'(1);
              top_r <= AW'(1);
              ra_r  <= AW'(1);
              state <= S_ROW;
            end
          end
        end
        S_ROW: begin
          // sweep from the row top down to entry 0
          if (ra_r == '0) begin
            state <= S_DRAIN;
          end else begin
            ra_r <= ra_r - AW'(1);
          end
        end
        S_DRAIN: begin
          // next row reads what this row writes: wait for the pipe to empty
          if (!rd_pend && !mm_busy) begin
            if (j_r == n_r) begin
              state <= S_FETCH;
            end else begin
              j_r   <= j_next;
              top_r <= top_next;
              ra_r  <= top_next;
              state <= S_ROW;
            end
          end
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          res_r <= rd_data;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_v || answer.ready) begin
            out_v     <= 1'b1;
            out_count <= res_r;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign query.ready        = (state == S_IDLE);
  assign answer.valid       = out_v;
  assign answer.data.count  = out_count;

  sfk_row_ram #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_row_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (row_wr)
  );

  sfk_mulmod u_mulmod (
    .clk  (clk),
    .rst  (rst),
    .req  (mm_req),
    .wr   (row_wr),
    .busy (mm_busy)
  );

endmodule

// File: src/sfk_checker.sv
// ---------------------------------------------------------------------------
// sfk_checker
// Port-level checks of the Stirling number block, bound to the top level.
// ---------------------------------------------------------------------------
`include "stirling_first_kind_mod_prime_top_macros.svh"

module sfk_checker import sfk_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               query_valid,
  input logic               query_ready,
  input logic               answer_valid,
  input logic               answer_ready,
  input logic [COUNT_W-1:0] answer_count
);

  logic       q_acc, a_acc;
  logic [1:0] pend;

  assign q_acc = query_valid && query_ready;
  assign a_acc = answer_valid && answer_ready;

  // queries taken minus answers delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      priority if (q_acc && !a_acc) begin
        pend <= pend + 2'd1;
      end else if (a_acc && !q_acc) begin
        pend <= pend - 2'd1;
      end else begin
        pend <= pend;
      end
    end
  end

  `SFK_ASSERT_NOW(a_count_range, clk, rst, answer_valid, answer_count < MODULUS, "count not reduced")

  `SFK_ASSERT_NOW(a_no_orphan, clk, rst, a_acc, pend != 2'd0, "answer without a pending query")

  `SFK_ASSERT_NOW(a_one_in_work, clk, rst, q_acc, pend <= 2'd1, "query taken while one is in work")

  `SFK_ASSERT_NEXT(a_answer_hold, clk, rst, answer_valid && !answer_ready, answer_valid && $stable(answer_count), "stalled answer changed")

endmodule

bind stirling_first_kind_mod_prime_top sfk_checker u_sfk_checker (
  .clk          (clk),
  .rst          (rst),
  .query_valid  (query.valid),
  .query_ready  (query.ready),
  .answer_valid (answer.valid),
  .answer_ready (answer.ready),
  .answer_count (answer.data.count)
);

// File: tb/tb_stirling_first_kind_mod_prime_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_stirling_first_kind_mod_prime_top
// Drives query transactions (n, k) into the Stirling number block and checks
// each answer against c(n,k) mod 1000000007, computed in the testbench by
// the row recurrence. Both handshake sides stall at random.
// ---------------------------------------------------------------------------
module tb_stirling_first_kind_mod_prime_top;
  import sfk_pkg::*;

  localparam int TB_MAX_N   = MAX_N_DEFAULT;
  localparam int N_DIRECTED = 22;
  localparam int N_RANDOM   = 78;

  logic clk;
  logic rst;
  int   idle_max;

  sfk_stream_if #(.payload_t(query_t))  query_if ();
  sfk_stream_if #(.payload_t(answer_t)) answer_if ();

  stirling_first_kind_mod_prime_top #(
    .MAX_N(TB_MAX_N)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .query  (query_if),
    .answer (answer_if)
  );

  // Expected counts, oldest first, and the row used to compute them
  class stirling_scoreboard;
    logic [COUNT_W-1:0] pending_counts[$];
    bit   [COUNT_W-1:0] work_row[0:TB_MAX_N];
    int                 mismatches;

    function logic [COUNT_W-1:0] stirling_count(int unsigned n, int unsigned k);
      longint unsigned modulus;
      longint unsigned acc;
      int unsigned     top;
      modulus = longint'(MODULUS);
      if (n == k) return 1;
      if (k > n || k == 0 || n > TB_MAX_N) return 0;
      work_row[0] = 1;
      for (int m = 1; m <= k; m++) work_row[m] = 0;
      // update in place from high m down so row j-1 is still readable
      for (int unsigned j = 1; j <= n; j++) begin
        top = (j < k) ? j : k;
        for (int m = top; m >= 1; m--) begin
          acc = longint'(j - 1) * longint'(work_row[m]) + longint'(work_row[m-1]);
          work_row[m] = COUNT_W'(acc % modulus);
        end
        work_row[0] = 0;
      end
      return work_row[k];
    endfunction

    function void note_query(query_t q);
      pending_counts.push_back(stirling_count(q.items, q.visible));
    endfunction

    function void check_answer(answer_t a);
      logic [COUNT_W-1:0] exp_count;
      if (pending_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected answer count=%0d", a.count);
        return;
      end
      exp_count = pending_counts.pop_front();
      if (a.count !== exp_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: count mismatch expected=%0d actual=%0d", exp_count, a.count);
      end
    endfunction
  endclass

  stirling_scoreboard sb = new();

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin
    #200_000_000;
    $display("stirling_first_kind_mod_prime_top regression: fail");
    $finish;
  end

  // One query transaction, after a random idle gap
  task automatic send_query(input int unsigned n, input int unsigned k);
    int     gap;
    query_t q;
    gap       = $urandom_range(0, idle_max);
    q.items   = n[ITEMS_W-1:0];
    q.visible = k[ITEMS_W-1:0];
    @(negedge clk);
    if (gap > 0) begin
      query_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    query_if.valid <= 1'b1;
    query_if.data  <= q;
    do @(posedge clk); while (!query_if.ready);
    sb.note_query(q);
  endtask

  // Hold off new queries until every answer is back
  task automatic drain_answers();
    @(negedge clk);
    query_if.valid <= 1'b0;
    while (sb.pending_counts.size() > 0) @(posedge clk);
  endtask

  // Answer side: random ready stalls
  initial begin
    int gap;
    answer_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
        answer_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      answer_if.ready <= 1'b1;
      do @(posedge clk); while (!answer_if.valid);
      sb.check_answer(answer_if.data);
      @(negedge clk);
    end
  end

  // Stimulus
  initial begin
    int unsigned directed_n[N_DIRECTED];
    int unsigned directed_k[N_DIRECTED];
    int unsigned n;
    int unsigned k;
    int          pick;

    directed_n = '{0, 2047, 1024, 0, 1, 2047, 1, 1024, 2047, 1025,
                   1, 2, 3, 3, 5, 10, 20, 7, 1024, 1024, 1023, 1024};
    directed_k = '{0, 2047, 1024, 2047, 2047, 0, 0, 0, 1, 1024,
                   1, 1, 1, 2, 2, 3, 10, 6, 1, 2, 1, 1023};

    rst            = 1'b1;
    idle_max       = 0;
    query_if.valid = 1'b0;
    query_if.data  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every special case, the largest row
    for (int i = 0; i < N_DIRECTED; i++) begin
      idle_max = (i < 8) ? 0 : 3;
      send_query(directed_n[i], directed_k[i]);
    end
    drain_answers();

    // Random: mostly real rows of small size, some trivial and out-of-range
    for (int r = 0; r < N_RANDOM; r++) begin
      idle_max = (r >= 20 && r < 35) ? 0 : 3;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        n = $urandom_range(2, 40);
        k = $urandom_range(1, n - 1);
      end else if (pick < 65) begin
        n = $urandom_range(41, TB_MAX_N);
        k = $urandom_range(1, 3);
      end else if (pick < 73) begin
        n = $urandom_range(0, 2047);
        k = n;
      end else if (pick < 81) begin
        n = $urandom_range(0, 2046);
        k = $urandom_range(n + 1, 2047);
      end else if (pick < 89) begin
        n = $urandom_range(1, 2047);
        k = 0;
      end else begin
        // beyond the row store: answered with zero
        n = $urandom_range(TB_MAX_N + 1, 2047);
        k = $urandom_range(1, n - 1);
      end
      send_query(n, k);
      if (r == N_RANDOM / 2) drain_answers();
    end

    // Wind down
    drain_answers();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_counts.size() == 0) begin
      $display("stirling_first_kind_mod_prime_top regression: pass");
    end else begin
      $display("stirling_first_kind_mod_prime_top regression: fail");
    end
    $finish;
  end

endmodule
